// File: hdl/pida_pkg.sv
// package for the positional insert/delete list
// widths, operation and status codes, cell control struct; no dependencies
package pida_pkg;

   localparam int CAPACITY = 64;

   localparam int KIND_W   = 2;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   // count holds 0..CAPACITY, a cell index 0..CAPACITY-1
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CIDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // common width for comparing positions against the count
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // removed-value pick: first level groups, second level merges the groups
   localparam int GROUP  = 8;
   localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_AT  = 2'd0,
      KIND_DEL_AT  = 2'd1,
      KIND_INS_END = 2'd2,
      KIND_DEL_END = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   localparam data_type NO_VALUE = '1;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [CMP_W-1:0] at;
      data_type         value;
   } cell_ctrl_type;

endpackage

// File: hdl/pida_req_if.sv
// request channel: valid/ready handshake with operation payload
// depends on pida_pkg
interface pida_req_if;
   import pida_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [POS_W-1:0]       position;
   logic signed [DATA_W-1:0] element;

   modport source (output valid, output kind, output position, output element, input ready);
   modport sink   (input valid, input kind, input position, input element, output ready);
endinterface

// File: hdl/pida_rsp_if.sv
// response channel: valid/ready handshake with status, removed value and length
// depends on pida_pkg
interface pida_rsp_if;
   import pida_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] removed_value;
   logic [LEN_W-1:0]         length;

   modport source (output valid, output status, output removed_value, output length,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input length,
                   output ready);
endinterface

// File: hdl/pida_cell.sv
// one storage cell of the list chain; shifts with its neighbours
// depends on pida_pkg
module pida_cell
(
   input  logic                          clock,
   input  logic [pida_pkg::CIDX_W-1:0]   idx,
   input  pida_pkg::cell_ctrl_type       ctrl,
   input  pida_pkg::data_type            lower,
   input  pida_pkg::data_type            upper,
   output pida_pkg::data_type            value_out,
   output pida_pkg::data_type            sel_out
);
   import pida_pkg::*;

   data_type         entry_ff;
   data_type         entry_in;
   logic [CMP_W-1:0] my_idx;

   assign my_idx = CMP_W'(idx);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (my_idx == ctrl.at) begin
            entry_in = ctrl.value;
         end else if (my_idx > ctrl.at) begin
            entry_in = lower;
         end
      end else if (ctrl.del) begin
         if (my_idx >= ctrl.at) begin
            entry_in = upper;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value_out = entry_ff;
   // offer own entry when addressed, for the removed-value pick
   assign sel_out   = (my_idx == ctrl.at) ? entry_ff : '0;
endmodule

// File: hdl/pida_reduce.sv
// two-level or-tree that picks the addressed entry out of the chain
// depends on pida_pkg
module pida_reduce
(
   input  logic                clock,
   input  logic                capture,
   input  pida_pkg::data_type  sel [pida_pkg::CAPACITY],
   output pida_pkg::data_type  picked
);
   import pida_pkg::*;

   data_type group_ff [NGROUP];
   data_type group_in [NGROUP];

   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < CAPACITY) begin
               group_in[g] = group_in[g] | sel[g * GROUP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      picked = '0;
      for (int g = 0; g < NGROUP; g++) begin
         picked = picked | group_ff[g];
      end
   end
endmodule

// File: hdl/positional_insert_delete_array.sv
// Positional insert/delete list of up to CAPACITY signed 32-bit entries held in
// a chain of cells, one entry per cell. A request inserts at an index (later
// entries move up), deletes at an index (later entries move down, removed value
// returned), or inserts/deletes at the tail. A bad index or a delete from an
// empty list gives status 1 and removed value -1; an insert into a full list
// gives status 2. Every response carries the length after the operation.
// Timing: the whole chain shifts in the cycle a request is taken, and the
// removed value comes out of a two-level or-tree with a registered first
// level, so a response passes the middle stage and then the response register.
// A new request is taken only once the previous one has left the middle stage,
// and a stalled response holds one more request behind it.
// Entry storage has no reset; only entries below the count are ever read.
// Depends on pida_pkg, pida_req_if, pida_rsp_if, pida_cell and pida_reduce.
module positional_insert_delete_array
(
   input  logic        clock,
   input  logic        reset,
   pida_req_if.sink    req_chan,
   pida_rsp_if.source  rsp_chan
);
   import pida_pkg::*;

   // list length
   logic [CNT_W-1:0]    count_ff, count_in;

   // middle stage, waiting for the or-tree
   logic                stage_vld_ff, stage_vld_in;
   status_type          stage_status_ff, stage_status_in;
   logic                stage_del_ff, stage_del_in;
   logic [LEN_W-1:0]    stage_len_ff, stage_len_in;

   // response register
   logic                rsp_vld_ff, rsp_vld_in;
   status_type          rsp_status_ff, rsp_status_in;
   data_type            rsp_removed_ff, rsp_removed_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   logic                req_accept;
   logic                stage_move;
   kind_type            kind;
   logic [CMP_W-1:0]    count_ext;
   logic [CMP_W-1:0]    at;
   logic                is_ins;
   status_type          status;
   logic                op_ok;
   cell_ctrl_type       ctrl;
   data_type            cell_val [CAPACITY];
   data_type            cell_sel [CAPACITY];
   data_type            picked;

   // handshakes: one request in flight ahead of the response register
   assign req_chan.ready = !stage_vld_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign stage_move     = stage_vld_ff && (!rsp_vld_ff || rsp_chan.ready);

   // decode the request into a target index and an insert/delete flag
   assign kind      = kind_type'(req_chan.kind);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      unique case (kind)
         KIND_INS_AT: begin
            at     = CMP_W'(req_chan.position);
            is_ins = 1'b1;
         end
         KIND_DEL_AT: begin
            at     = CMP_W'(req_chan.position);
            is_ins = 1'b0;
         end
         KIND_INS_END: begin
            at     = count_ext;
            is_ins = 1'b1;
         end
         default: begin
            // tail delete; an empty list wraps to all ones and fails the range check
            at     = count_ext - CMP_W'(1);
            is_ins = 1'b0;
         end
      endcase
   end

   // range check comes before the full check for inserts
   always_comb begin
      if (is_ins) begin
         if (at > count_ext) begin
            status = ST_BAD;
         end else if (count_ff == CNT_W'(CAPACITY)) begin
            status = ST_FULL;
         end else begin
            status = ST_DONE;
         end
      end else begin
         if (at >= count_ext) begin
            status = ST_BAD;
         end else begin
            status = ST_DONE;
         end
      end
   end

   assign op_ok = (status == ST_DONE);

   always_comb begin
      ctrl.ins   = req_accept && op_ok && is_ins;
      ctrl.del   = req_accept && op_ok && !is_ins;
      ctrl.at    = at;
      ctrl.value = req_chan.element;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // the chain: each cell sees its lower and upper neighbour
   for (genvar g = 0; g < CAPACITY; g++) begin : gen_cell
      data_type lower_nb;
      data_type upper_nb;
      if (g == 0) begin : gen_first
         assign lower_nb = '0;
      end else begin : gen_mid_lo
         assign lower_nb = cell_val[g-1];
      end
      if (g == CAPACITY - 1) begin : gen_last
         assign upper_nb = '0;
      end else begin : gen_mid_hi
         assign upper_nb = cell_val[g+1];
      end

      pida_cell u_cell (
         .clock     (clock),
         .idx       (CIDX_W'(g)),
         .ctrl      (ctrl),
         .lower     (lower_nb),
         .upper     (upper_nb),
         .value_out (cell_val[g]),
         .sel_out   (cell_sel[g])
      );
   end

   // grabs the addressed entry before the shift lands
   pida_reduce u_reduce (
      .clock   (clock),
      .capture (req_accept),
      .sel     (cell_sel),
      .picked  (picked)
   );

   always_comb begin
      stage_vld_in    = stage_vld_ff;
      stage_status_in = stage_status_ff;
      stage_del_in    = stage_del_ff;
      stage_len_in    = stage_len_ff;
      if (req_accept) begin
         stage_vld_in    = 1'b1;
         stage_status_in = status;
         stage_del_in    = op_ok && !is_ins;
         stage_len_in    = LEN_W'(count_in);
      end else if (stage_move) begin
         stage_vld_in    = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in     = rsp_vld_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_len_in     = rsp_len_ff;
      if (stage_move) begin
         rsp_vld_in     = 1'b1;
         rsp_status_in  = stage_status_ff;
         rsp_removed_in = stage_del_ff ? picked : NO_VALUE;
         rsp_len_in     = stage_len_ff;
      end else if (rsp_chan.ready) begin
         rsp_vld_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      stage_status_ff <= stage_status_in;
      stage_del_ff    <= stage_del_in;
      stage_len_ff    <= stage_len_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_len_ff      <= rsp_len_in;
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status        = STATUS_W'(rsp_status_ff);
   assign rsp_chan.removed_value = rsp_removed_ff;
   assign rsp_chan.length        = rsp_len_ff;
endmodule
